// ----- rtl/adu_pkg.sv -----
`default_nettype none
// adu_pkg: widths, operation codes, queue item type and exponent table builder.
// Used by every module of the activation and derivative unit; no dependencies.
package adu_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned DW        = 16;
  localparam int unsigned FKW       = 2;
  localparam int unsigned AW        = DW + 1;
  localparam int unsigned DIG       = 4;
  localparam int unsigned NCHUNK    = (AW + DIG - 1) / DIG;
  localparam int unsigned AP        = NCHUNK * DIG;
  localparam int unsigned XW        = 32;
  localparam int unsigned XF        = XW - 1;
  localparam int unsigned QB        = FRAC_BITS + 2;
  localparam int unsigned MW        = (FRAC_BITS > DW - 1) ? FRAC_BITS : DW - 1;
  localparam int unsigned PW        = 2 * MW + 3;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPW       = $clog2(QDEPTH);
  localparam int unsigned NPIPE     = NCHUNK + QB + 1;
  localparam int unsigned BK_STAGES = NPIPE + 1;

  localparam logic [63:0] ONE62 = 64'd1 << 62;

  typedef enum logic [FKW-1:0] {
    FK_SIGMOID,
    FK_TANH,
    FK_RELU,
    FK_PASS
  } fkind_e;

  typedef enum logic [2:0] {
    OP_SIG,
    OP_TANH,
    OP_RELU,
    OP_PASS,
    OP_DSIG,
    OP_DTANH,
    OP_DRELU,
    OP_DPASS
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic                 neg;
    logic [AP-1:0]        arg;
    logic signed [DW-1:0] val;
  } item_t;

  function automatic logic [63:0] mul62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // exp(-2^-FRAC_BITS) in Q2.62
  function automatic logic [63:0] exp_unit();
    logic [63:0] s;
    s = ONE62;
    s = s - (ONE62 >> FRAC_BITS);
    s = s + ((ONE62 >> (2 * FRAC_BITS)) / 2);
    s = s - ((ONE62 >> (3 * FRAC_BITS)) / 6);
    s = s + ((ONE62 >> (4 * FRAC_BITS)) / 24);
    s = s - ((ONE62 >> (5 * FRAC_BITS)) / 120);
    s = s + ((ONE62 >> (6 * FRAC_BITS)) / 720);
    s = s - ((ONE62 >> (7 * FRAC_BITS)) / 5040);
    s = s + ((ONE62 >> (8 * FRAC_BITS)) / 40320);
    return s;
  endfunction

  // exp(-d * 2^(c*DIG - FRAC_BITS)) in Q1.XF
  function automatic logic [XW-1:0] exp_tab(int unsigned c, int unsigned d);
    logic [63:0] base;
    logic [63:0] acc;
    int unsigned k;
    base = exp_unit();
    for (k = 0; k < c * DIG; k++) begin
      base = mul62(base, base);
    end
    acc = ONE62;
    for (k = 0; k < d; k++) begin
      acc = mul62(acc, base);
    end
    return acc[62-XF +: XW];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/activation_and_derivative_unit.sv -----
// Activation and derivative unit, Q4.12 operands (FRAC_BITS fraction bits).
//
// Slave stream: s_axis_tdata_i carries value_in, s_axis_tuser_i the command
// (0 activate, 1 derivative of the activated value). Master stream:
// m_axis_tdata_o carries value_out, rounded and saturated to 16 bits.
// cfg_we_i/cfg_wdata_i write function_kind (sigmoid, tanh, relu, passthrough);
// write it only while the unit is empty.
//
// Pipeline: an accepted input beat passes the queue slot, five exponent table
// stages, one divider setup stage, fourteen divider steps and the output
// register before its output beat is valid.
// Throughput: one beat per cycle when not stalled (fully pipelined divider).
// Reset: function kind sigmoid, queue and pipeline empty.
// Stall: while an output beat waits on a low m_axis_tready_i the pipeline holds,
// the four-entry queue keeps taking beats, and s_axis_tready_o drops when full.
`default_nettype none
module activation_and_derivative_unit import adu_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [DW-1:0]  s_axis_tdata_i,   // [15:0] value_in
  input  logic           s_axis_tuser_i,   // [0] command
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [DW-1:0]  m_axis_tdata_o,   // [15:0] value_out
  input  logic           cfg_we_i,
  input  logic [FKW-1:0] cfg_wdata_i
);

  logic  push;
  item_t push_item;
  logic  full;
  logic  q_valid;
  item_t q_head;
  logic  pop;

  adu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  adu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  adu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (q_valid),
    .item_i          (q_head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

// ----- rtl/adu_front.sv -----
`default_nettype none
// adu_front: input beat intake, function kind register and item classification.
// Depends on adu_pkg; feeds adu_queue.
module adu_front import adu_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [DW-1:0]  s_axis_tdata_i,   // [15:0] value_in
  input  logic           s_axis_tuser_i,   // [0] command
  input  logic           cfg_we_i,
  input  logic [FKW-1:0] cfg_wdata_i,
  input  logic           full_i,
  output logic           push_o,
  output item_t          item_o
);

  fkind_e               fkind_q;
  logic signed [DW-1:0] val;
  logic                 neg;
  logic [DW-1:0]        mag;
  op_e                  op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fkind_q <= FK_SIGMOID;
    end else if (cfg_we_i) begin
      fkind_q <= fkind_e'(cfg_wdata_i);
    end
  end

  always_comb begin
    val = $signed(s_axis_tdata_i);
    neg = val[DW-1];
    mag = neg ? DW'(-val) : DW'(val);
    case (fkind_q)
      FK_SIGMOID: op = s_axis_tuser_i ? OP_DSIG : OP_SIG;
      FK_TANH:    op = s_axis_tuser_i ? OP_DTANH : OP_TANH;
      FK_RELU:    op = s_axis_tuser_i ? OP_DRELU : OP_RELU;
      default:    op = s_axis_tuser_i ? OP_DPASS : OP_PASS;
    endcase
    item_o.op  = op;
    item_o.neg = neg;
    item_o.val = val;
    item_o.arg = (op == OP_TANH) ? AP'({mag, 1'b0}) : AP'(mag);
  end

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

endmodule
`default_nettype wire

// ----- rtl/adu_queue.sv -----
`default_nettype none
// adu_queue: short item queue between the front and back parts.
// Depends on adu_pkg.
module adu_queue import adu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t head_o
);

  item_t          mem_q [QDEPTH];
  logic [QPW-1:0] wr_q;
  logic [QPW-1:0] rd_q;
  logic [QPW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign full_o  = (cnt_q == (QPW + 1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

endmodule
`default_nettype wire

// ----- rtl/adu_back.sv -----
`default_nettype none
// adu_back: execution pipeline (table exponent chain, restoring divider,
// derivative products, rounding and saturation) with the output register.
// Depends on adu_pkg; takes items from adu_queue.
module adu_back import adu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  item_t         item_i,
  output logic          pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [DW-1:0] m_axis_tdata_o   // [15:0] value_out
);

  typedef struct packed {
    op_e                  op;
    logic                 neg;
    logic signed [DW-1:0] val;
    logic [DW-1:0]        dres;
  } ctl_t;

  localparam logic [XW-1:0]        ONE_X  = {{(XW-1){1'b0}}, 1'b1} << XF;
  localparam logic signed [PW-1:0] ONE_SQ = {{(PW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);
  localparam logic [PW-1:0]        HALF   = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] SMAX   = PW'(2 ** (DW - 1) - 1);
  localparam logic signed [PW-1:0] SMIN   = ~SMAX;

  function automatic logic [DW-1:0] sat_dw(logic signed [PW-1:0] x);
    logic [DW-1:0] r;
    if (x > SMAX) begin
      r = SMAX[DW-1:0];
    end else if (x < SMIN) begin
      r = SMIN[DW-1:0];
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [PW-1:0] round_fb(logic signed [PW-1:0] x);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = x[PW-1] ? PW'(-x) : PW'(x);
    r   = (mag + HALF) >> FRAC_BITS;
    return x[PW-1] ? -$signed(r) : $signed(r);
  endfunction

  logic                   adv;
  logic [NPIPE-1:0]       vld_q;
  ctl_t                   ctl_q [NPIPE];
  ctl_t                   ctl_d [NPIPE];
  logic [XW-1:0]          tab   [NCHUNK][2**DIG];
  logic [XW-1:0]          ex_q  [NCHUNK];
  logic [XW-1:0]          ex_d  [NCHUNK];
  logic [AP-1:0]          arg_q [NCHUNK-1];
  logic [AP-1:0]          arg_d [NCHUNK-1];
  logic signed [2*DW-1:0] sq;
  logic signed [PW-1:0]   vx;
  logic signed [PW-1:0]   dp_q;
  logic signed [PW-1:0]   dp_d;
  logic [XW+1:0]          rm_q  [QB];
  logic [XW+1:0]          rm_d  [QB];
  logic [XW:0]            dn_q  [QB];
  logic [XW:0]            dn_d  [QB];
  logic [QB-1:0]          qt_q  [QB];
  logic [QB-1:0]          qt_d  [QB];
  logic [XW-1:0]          e_fin;
  logic [XW-1:0]          num;
  logic [QB:0]            qs;
  logic signed [PW-1:0]   act;
  logic signed [PW-1:0]   res;
  ctl_t                   c_out;
  logic                   out_v_q;
  logic [DW-1:0]          out_q;
  logic [DW-1:0]          out_d;

  assign adv   = !out_v_q || m_axis_tready_i;
  assign pop_o = adv && in_valid_i;

  // exponent tables, one per digit of the argument
  for (genvar c = 0; c < NCHUNK; c++) begin : g_tab
    for (genvar d = 0; d < 2**DIG; d++) begin : g_ent
      localparam logic [XW-1:0] TV = exp_tab(c, d);
      assign tab[c][d] = TV;
    end
  end

  // exponent chain: one digit per stage
  for (genvar c = 0; c < NCHUNK; c++) begin : g_exp
    logic [AP-1:0]   a_in;
    logic [DIG-1:0]  dg;
    if (c == 0) begin : g_first
      assign a_in     = item_i.arg;
      assign dg       = a_in[c*DIG +: DIG];
      assign ex_d[c]  = tab[c][dg];
    end else begin : g_mul
      logic [2*XW-1:0] pr;
      assign a_in     = arg_q[c-1];
      assign dg       = a_in[c*DIG +: DIG];
      assign pr       = ex_q[c-1] * tab[c][dg];
      assign ex_d[c]  = pr[XF +: XW];
    end
    if (c < NCHUNK - 1) begin : g_arg
      assign arg_d[c] = a_in;
    end
  end

  // divider setup
  assign e_fin = ex_q[NCHUNK-1];
  always_comb begin
    case (ctl_q[NCHUNK-1].op)
      OP_SIG:  num = ctl_q[NCHUNK-1].neg ? e_fin : ONE_X;
      OP_TANH: num = ONE_X - e_fin;
      default: num = ONE_X;
    endcase
  end
  assign rm_d[0] = (XW + 2)'(num);
  assign dn_d[0] = {1'b0, ONE_X} + {1'b0, e_fin};

  // restoring divider: one quotient bit per stage
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [QB-1:0] q_in;
    logic          ge;
    assign ge    = rm_q[i] >= {1'b0, dn_q[i]};
    if (i == 0) begin : g_q0
      assign q_in = '0;
    end else begin : g_qn
      assign q_in = qt_q[i-1];
    end
    assign qt_d[i] = {q_in[QB-2:0], ge};
    if (i < QB - 1) begin : g_fwd
      logic [XW+1:0] r_sub;
      assign r_sub     = ge ? rm_q[i] - {1'b0, dn_q[i]} : rm_q[i];
      assign rm_d[i+1] = {r_sub[XW:0], 1'b0};
      assign dn_d[i+1] = dn_q[i];
    end
  end

  // derivative products
  assign sq = item_i.val * item_i.val;
  assign vx = PW'(item_i.val);
  always_comb begin
    case (item_i.op)
      OP_DSIG:  dp_d = (vx <<< FRAC_BITS) - PW'(sq);
      OP_DTANH: dp_d = ONE_SQ - PW'(sq);
      OP_DRELU: dp_d = item_i.neg ? '0 : ONE_SQ;
      default:  dp_d = ONE_SQ;
    endcase
  end

  always_comb begin
    ctl_d[0].op   = item_i.op;
    ctl_d[0].neg  = item_i.neg;
    ctl_d[0].val  = item_i.val;
    ctl_d[0].dres = '0;
    for (int s = 1; s < NPIPE; s++) begin
      ctl_d[s] = ctl_q[s-1];
    end
    ctl_d[1].dres = sat_dw(round_fb(dp_q));
  end

  // result select and saturation
  assign c_out = ctl_q[NPIPE-1];
  assign qs    = {1'b0, qt_q[QB-1]} + 1'b1;
  assign act   = $signed(PW'(qs[QB:1]));
  always_comb begin
    res   = act;
    out_d = c_out.dres;
    case (c_out.op)
      OP_SIG: begin
        res   = act;
        out_d = sat_dw(res);
      end
      OP_TANH: begin
        res   = c_out.neg ? -act : act;
        out_d = sat_dw(res);
      end
      OP_RELU: begin
        res   = c_out.neg ? '0 : PW'($signed(c_out.val));
        out_d = sat_dw(res);
      end
      OP_PASS: begin
        res   = PW'($signed(c_out.val));
        out_d = sat_dw(res);
      end
      default: begin
        res   = act;
        out_d = c_out.dres;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      vld_q   <= {vld_q[NPIPE-2:0], in_valid_i};
      out_v_q <= vld_q[NPIPE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q <= ctl_d;
      ex_q  <= ex_d;
      arg_q <= arg_d;
      dp_q  <= dp_d;
      rm_q  <= rm_d;
      dn_q  <= dn_d;
      qt_q  <= qt_d;
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

endmodule
`default_nettype wire

// ----- rtl/adu_checker.sv -----
`default_nettype none
// adu_props: port-level checks on beat ordering and occupancy of the unit.
// Depends on adu_pkg; bound to activation_and_derivative_unit below.
module adu_props import adu_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tvalid_i,
  input logic          s_axis_tready_o,
  input logic          m_axis_tvalid_o,
  input logic          m_axis_tready_i,
  input logic [DW-1:0] m_axis_tdata_o
);

  localparam int unsigned OMAX = QDEPTH + BK_STAGES;
  localparam int unsigned OCW  = $clog2(OMAX + 1) + 1;

  logic           in_acc;
  logic           out_acc;
  logic [OCW-1:0] outst_q;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (in_acc && !out_acc) begin
      outst_q <= outst_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      outst_q <= outst_q - 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> outst_q != '0)
    else $error("output beat without a pending input beat");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= OCW'(OMAX))
    else $error("more beats in flight than queue and pipeline hold");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q == '0 |-> s_axis_tready_o)
    else $error("empty unit refuses input");

endmodule

bind activation_and_derivative_unit adu_props u_adu_props (.*);
`default_nettype wire

// ----- tb/sv/adu_tb_pkg.sv -----
`timescale 1ns / 100ps
// adu_tb_pkg: command codes shared by the activation unit testbench and checker.
// No dependencies.
package adu_tb_pkg;

  typedef enum logic {
    CMD_ACTIVATE,
    CMD_DERIVE
  } adu_cmd_e;

endpackage

// ----- tb/sv/adu_checker.sv -----
`timescale 1ns / 100ps
// adu_checker: watches the stream and configuration ports of the activation unit,
// predicts every output beat in Q2.62 fixed point and compares it with the block.
// Depends on adu_pkg (widths, function kinds) and adu_tb_pkg (command codes).
module adu_checker import adu_pkg::*; import adu_tb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  input  logic           s_axis_tready_i,
  input  logic [DW-1:0]  s_axis_tdata_i,
  input  logic           s_axis_tuser_i,
  input  logic           m_axis_tvalid_i,
  input  logic           m_axis_tready_i,
  input  logic [DW-1:0]  m_axis_tdata_i,
  input  logic           cfg_we_i,
  input  logic [FKW-1:0] cfg_wdata_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);

  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam longint      FX_ONE  = 64'sd1 <<< FRAC_BITS;

  typedef struct {
    logic [DW-1:0] value;
    logic          approx;
  } value_out_exp_t;

  value_out_exp_t        value_out_q[$];
  value_out_exp_t        head;
  fkind_e                active_kind;
  logic signed [DW:0]    diff;

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod >> 62);
  endfunction

  // exp(-y) for y in [0, 1], alternating series summed in two halves
  function automatic logic [63:0] taylor_exp_q62(logic [63:0] y);
    logic [63:0] term;
    logic [63:0] sum_even;
    logic [63:0] sum_odd;
    term     = Q62_ONE;
    sum_even = Q62_ONE;
    sum_odd  = 64'd0;
    for (int k = 1; k <= 27; k++) begin
      term = mul_q62(term, y) / 64'(k);
      if (k % 2) sum_odd += term;
      else       sum_even += term;
    end
    return sum_even - sum_odd;
  endfunction

  function automatic logic [63:0] exp_neg_q62(logic [17:0] a);
    logic [63:0] r;
    logic [63:0] e_one;
    int unsigned whole;
    whole = a >> FRAC_BITS;
    r     = taylor_exp_q62(64'(a[FRAC_BITS-1:0]) << (62 - FRAC_BITS));
    e_one = taylor_exp_q62(Q62_ONE);
    for (int i = 0; i < whole && r != 0; i++) r = mul_q62(r, e_one);
    return r;
  endfunction

  function automatic logic [63:0] ratio_round(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = num / den;
    rem = num % den;
    for (int i = 0; i <= FRAC_BITS; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

  function automatic longint shift_round(longint p);
    longint mag;
    mag = (p < 0) ? -p : p;
    mag = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic logic [DW-1:0] calc_value_out(fkind_e kind, adu_cmd_e cmd,
                                                   logic [DW-1:0] raw);
    longint      v;
    longint      res;
    logic [17:0] mag;
    logic [63:0] e;
    v   = longint'($signed(raw));
    mag = 18'((v < 0) ? -v : v);
    res = 0;
    if (cmd == CMD_ACTIVATE) begin
      case (kind)
        FK_SIGMOID: begin
          e   = exp_neg_q62(mag);
          res = longint'(ratio_round((v < 0) ? e : Q62_ONE, Q62_ONE + e));
        end
        FK_TANH: begin
          e   = exp_neg_q62(mag << 1);
          res = longint'(ratio_round(Q62_ONE - e, Q62_ONE + e));
          if (v < 0) res = -res;
        end
        FK_RELU: res = (v < 0) ? 0 : v;
        default: res = v;
      endcase
    end else begin
      case (kind)
        FK_SIGMOID: res = shift_round((FX_ONE - v) * v);
        FK_TANH:    res = shift_round(FX_ONE * FX_ONE - v * v);
        FK_RELU:    res = (v < 0) ? 0 : FX_ONE;
        default:    res = FX_ONE;
      endcase
    end
    if (res > 32767)  res = 32767;
    if (res < -32768) res = -32768;
    return res[DW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_kind = FK_SIGMOID;
      value_out_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        head.value  = calc_value_out(active_kind, adu_cmd_e'(s_axis_tuser_i), s_axis_tdata_i);
        head.approx = (s_axis_tuser_i == CMD_ACTIVATE) &&
                      (active_kind == FK_SIGMOID || active_kind == FK_TANH);
        value_out_q = {value_out_q, head};
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (value_out_q.size() == 0) begin
          $error("value_out: no result expected, actual %0d", $signed(m_axis_tdata_i));
          fail_count_o++;
        end else begin
          head = value_out_q.pop_front();
          diff = $signed({m_axis_tdata_i[DW-1], m_axis_tdata_i}) -
                 $signed({head.value[DW-1], head.value});
          if (head.approx ? (diff < -1 || diff > 1) : (diff != 0)) begin
            $error("value_out mismatch: expected %0d, actual %0d",
                   $signed(head.value), $signed(m_axis_tdata_i));
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) active_kind = fkind_e'(cfg_wdata_i);
      pending_o = value_out_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: drives the activation and derivative unit with directed and random
// beats under random idling and back-pressure; adu_checker scores the output.
// Depends on adu_pkg, adu_tb_pkg, adu_checker and the unit itself.
module testbench import adu_pkg::*; import adu_tb_pkg::*;;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [DW-1:0]  s_tdata = '0;
  logic           s_tuser = CMD_ACTIVATE;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [DW-1:0]  m_tdata;
  logic           cfg_we = 1'b0;
  logic [FKW-1:0] cfg_wdata = FK_SIGMOID;
  int unsigned    fail_count;
  int unsigned    pending;
  logic           idle_on = 1'b1;
  int unsigned    stall_left = 0;

  always #6 clk_i = ~clk_i;

  activation_and_derivative_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  adu_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_beat(input adu_cmd_e cmd, input logic [DW-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // drop valid and hold until every result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_kind(input fkind_e kind);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= kind;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [DW-1:0] rand_value();
    case ($urandom_range(0, 3))
      0:       return DW'($urandom);
      1:       return DW'($urandom_range(0, 16384) - 8192);
      2:       return DW'($urandom_range(0, 8192) - 4096);
      default: begin
        case ($urandom_range(0, 5))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          3:       return 16'hffff;
          4:       return 16'h1000;
          default: return 16'hf000;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [DW-1:0] dir_val [6];
    fkind_e        kind;
    dir_val = '{16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff, 16'hffff};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < 4; k++) begin
      write_kind(fkind_e'(k));
      for (int i = 0; i < 6; i++) begin
        send_beat((i < 3) ? CMD_ACTIVATE : CMD_DERIVE, dir_val[i]);
      end
    end
    for (int phase = 0; phase < 8; phase++) begin
      kind = (phase < 4) ? fkind_e'(3 - phase) : fkind_e'($urandom_range(0, 3));
      write_kind(kind);
      idle_on = (phase == 7) ? 1'b0 : ($urandom_range(0, 4) != 0);
      for (int i = 0; i < 106; i++) begin
        send_beat(adu_cmd_e'($urandom_range(0, 1)), rand_value());
      end
    end
    drain();
    repeat (30) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending != 0) $error("value_out: %0d expected results never arrived", pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
